/* hw/rtl/sbr_pkg.sv */
`timescale 1ns / 1ps

package sbr_pkg;

   localparam logic [31:0] MAGIC_WORD      = 32'h2112A442;
   localparam logic [15:0] RESP_TYPE       = 16'h0101;
   localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
   localparam logic [15:0] ATTR_MAPPED     = 16'h0001;
   localparam logic [15:0] REQ_TYPE        = 16'h0001;
   localparam logic [7:0]  FAMILY_V4       = 8'h01;
   localparam logic [7:0]  FAMILY_V6       = 8'h02;

   localparam logic [15:0] ATTR_LEN_V4 = 16'd8;
   localparam logic [15:0] ATTR_LEN_V6 = 16'd20;

   // Seven leading words plus one for IPv4, four for IPv6.
   localparam int unsigned MAX_WORDS = 11;
   localparam int unsigned IDX_W     = $clog2(MAX_WORDS);

   typedef logic [IDX_W-1:0] idx_type;

   localparam idx_type W_HEADER   = 4'd0;
   localparam idx_type W_COOKIE   = 4'd1;
   localparam idx_type W_TXID0    = 4'd2;
   localparam idx_type W_TXID1    = 4'd3;
   localparam idx_type W_TXID2    = 4'd4;
   localparam idx_type W_ATTR     = 4'd5;
   localparam idx_type W_PORT     = 4'd6;
   localparam idx_type W_ADDR0    = 4'd7;
   localparam idx_type W_ADDR1    = 4'd8;
   localparam idx_type W_ADDR2    = 4'd9;
   localparam idx_type W_ADDR3    = 4'd10;
   localparam idx_type W_LAST_V4  = W_ADDR0;
   localparam idx_type W_LAST_V6  = W_ADDR3;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_TYPE = 2'd1,
      STATUS_HAS_ATTR = 2'd2
   } status_type;

endpackage

/* hw/rtl/stun_binding_responder.sv */
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// request   start high, busy low    req_msg_type .. req_src_port
// response  rsp_valid strobe        rsp_resp_word, rsp_status, rsp_last_word
//
// A request gives 8 response words for an IPv4 answer, 11 for IPv6 and 1 for a reject,
// one response word per cycle out of the working register.
// The first word passes from the working register into the response registers and is shown on the response ports.
// The next request is taken at the edge that loads the current last word for output.
// Reset is synchronous and clears the working and response valid flags.
// The receiver cannot stall; every word is shown for exactly one cycle.
module stun_binding_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_msg_type,
   input  logic [15:0] req_msg_length,
   input  logic [31:0] req_cookie,
   input  logic [31:0] req_txid_high,
   input  logic [63:0] req_txid_low,
   input  logic        req_src_is_v6,
   input  logic [63:0] req_src_addr_high,
   input  logic [63:0] req_src_addr_low,
   input  logic [15:0] req_src_port,
   output logic        rsp_valid,
   output logic [31:0] rsp_resp_word,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_word
);

   logic                  work_valid_ff;
   sbr_pkg::idx_type      idx_ff;
   sbr_pkg::status_type   status_ff;
   logic                  v6_ff;
   logic                  xor_ff;
   logic [31:0]           cookie_ff;
   logic [31:0]           txid_high_ff;
   logic [63:0]           txid_low_ff;
   logic [63:0]           addr_high_ff;
   logic [63:0]           addr_low_ff;
   logic [15:0]           port_ff;

   logic                  rsp_valid_ff;
   logic [31:0]           rsp_word_ff;
   sbr_pkg::status_type   rsp_status_ff;
   logic                  rsp_last_ff;

   logic                  accept;
   logic                  use_v6_in;
   sbr_pkg::status_type   status_in;
   logic                  last_in;
   logic [31:0]           word_in;
   logic [15:0]           attr_len;
   logic [31:0]           mask;

   assign accept = start && !busy;

   // An IPv4-mapped IPv6 sender (::ffff:a.b.c.d) is answered as IPv4.
   assign use_v6_in = req_src_is_v6 &&
                      !((req_src_addr_high == 64'd0) &&
                        (req_src_addr_low[63:32] == 32'h0000FFFF));

   always_comb begin
      priority if (req_msg_type != sbr_pkg::REQ_TYPE) begin
         status_in = sbr_pkg::STATUS_BAD_TYPE;
      end else if (req_msg_length != 16'd0) begin
         status_in = sbr_pkg::STATUS_HAS_ATTR;
      end else begin
         status_in = sbr_pkg::STATUS_OK;
      end
   end

   assign last_in = (status_ff != sbr_pkg::STATUS_OK) ||
                    (idx_ff == (v6_ff ? sbr_pkg::W_LAST_V6 : sbr_pkg::W_LAST_V4));
   assign busy    = work_valid_ff && !last_in;

   assign attr_len = v6_ff ? sbr_pkg::ATTR_LEN_V6 : sbr_pkg::ATTR_LEN_V4;

   always_comb begin
      unique case (idx_ff)
         sbr_pkg::W_ADDR0: mask = v6_ff ? cookie_ff : sbr_pkg::MAGIC_WORD;
         sbr_pkg::W_ADDR1: mask = txid_high_ff;
         sbr_pkg::W_ADDR2: mask = txid_low_ff[63:32];
         sbr_pkg::W_ADDR3: mask = txid_low_ff[31:0];
         default:          mask = 32'd0;
      endcase
      if (!xor_ff) begin
         mask = 32'd0;
      end
   end

   always_comb begin
      unique case (idx_ff)
         sbr_pkg::W_HEADER: word_in = {sbr_pkg::RESP_TYPE, attr_len + 16'd4};
         sbr_pkg::W_COOKIE: word_in = cookie_ff;
         sbr_pkg::W_TXID0:  word_in = txid_high_ff;
         sbr_pkg::W_TXID1:  word_in = txid_low_ff[63:32];
         sbr_pkg::W_TXID2:  word_in = txid_low_ff[31:0];
         sbr_pkg::W_ATTR:   word_in = {xor_ff ? sbr_pkg::ATTR_XOR_MAPPED
                                              : sbr_pkg::ATTR_MAPPED, attr_len};
         sbr_pkg::W_PORT:   word_in = {8'd0,
                                       v6_ff ? sbr_pkg::FAMILY_V6 : sbr_pkg::FAMILY_V4,
                                       port_ff ^ (xor_ff ? sbr_pkg::MAGIC_WORD[31:16]
                                                         : 16'd0)};
         sbr_pkg::W_ADDR0:  word_in = (v6_ff ? addr_high_ff[63:32] : addr_low_ff[31:0])
                                      ^ mask;
         sbr_pkg::W_ADDR1:  word_in = addr_high_ff[31:0] ^ mask;
         sbr_pkg::W_ADDR2:  word_in = addr_low_ff[63:32] ^ mask;
         sbr_pkg::W_ADDR3:  word_in = addr_low_ff[31:0] ^ mask;
         default:           word_in = 32'd0;
      endcase
      if (status_ff != sbr_pkg::STATUS_OK) begin
         word_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            work_valid_ff <= 1'b1;
         end else if (work_valid_ff && last_in) begin
            work_valid_ff <= 1'b0;
         end
         rsp_valid_ff <= work_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff       <= sbr_pkg::W_HEADER;
         status_ff    <= status_in;
         v6_ff        <= use_v6_in;
         xor_ff       <= (req_cookie == sbr_pkg::MAGIC_WORD);
         cookie_ff    <= req_cookie;
         txid_high_ff <= req_txid_high;
         txid_low_ff  <= req_txid_low;
         addr_high_ff <= req_src_addr_high;
         addr_low_ff  <= req_src_addr_low;
         port_ff      <= req_src_port;
      end else if (work_valid_ff) begin
         idx_ff <= idx_ff + sbr_pkg::idx_type'(1);
      end
      rsp_word_ff   <= word_in;
      rsp_status_ff <= status_ff;
      rsp_last_ff   <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_resp_word = rsp_word_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last_word = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_reject_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != sbr_pkg::STATUS_OK) |-> rsp_last_word)
      else $error("reject result not marked as last");

   a_first_word : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("no response word two cycles after a request");

   a_busy_emits : assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("busy without a word in flight");

   a_more_follows : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |-> work_valid_ff)
      else $error("response ended without a last word");
`endif

endmodule
